[src/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int COPY_N   = COLUMNS * (ROWS - 1);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int POS_W    = 12;
  localparam int FUNC_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int CELL_W   = 2 * BYTE_W;

  localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SET   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd3;

  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [BYTE_W-1:0] TAB_STEP   = 8'd8;
  localparam logic [BYTE_W-1:0] TAB_MASK   = ~8'd7;
  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'd7;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_SCROLL,
    ST_DRAIN,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } state_t;

  function automatic logic [POS_W-1:0] cell_pos(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    cell_pos = POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col);
  endfunction

endpackage

`default_nettype wire

[src/tcw_if.sv]
`default_nettype none

interface tcw_cmd_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] char_code;
  logic [COL_W-1:0]  target_col;
  logic [ROW_W-1:0]  target_row;

  modport source (output valid, func, char_code, target_col, target_row, input ready);
  modport sink   (input valid, func, char_code, target_col, target_row, output ready);
endinterface

interface tcw_res_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [POS_W-1:0]  cursor_position;
  logic [BYTE_W-1:0] read_char;
  logic [BYTE_W-1:0] read_attr;

  modport source (output valid, cursor_col, cursor_row, cursor_position, read_char,
                  read_attr, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_position, read_char,
                  read_attr, output ready);
endinterface

`default_nettype wire

[src/text_console_writer.sv]
`default_nettype none

// Text console with a single-port-write, registered-read screen store of
// COLUMNS x ROWS cells (character in the low byte, attribute in the high byte)
// and a cursor. After reset the block sweeps the store to blanks with the reset
// attribute, one cell a cycle, across every cell before it takes its first
// command; configuration writes are taken throughout. A command is handled
// one at a time: cursor moves, newline, return, tab, a backspace at column
// zero or on the off-screen row and an out-of-range read go straight to the
// done state; a printable character or a backspace that blanks a cell passes
// through the write state, and a cell read through the read state, as the
// store has a single write port and a registered read port. A printable
// character below the last row scrolls the screen, copying one cell a cycle
// and then blanking the last row; a clear sweeps the whole store. The result
// register lets the next command be taken while a result waits on the output.

module text_console_writer import tcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [BYTE_W-1:0] cfg_wdata,
  tcw_cmd_if.sink                cmd,
  tcw_res_if.source              res
);

  logic [CELL_W-1:0] screen [CELLS];
  logic [CELL_W-1:0] mem_q;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CELL_W-1:0] mem_wd;

  state_t            state, state_next;
  logic [BYTE_W-1:0] attr;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] idx;
  logic              cp_valid;
  logic [ADDR_W-1:0] cp_addr;
  logic              pend_wr;
  logic              busy;
  logic [ADDR_W-1:0] waddr;
  logic [BYTE_W-1:0] pch;
  logic [BYTE_W-1:0] rd_char;
  logic [BYTE_W-1:0] rd_attr;

  logic              accept;
  logic              in_range;
  logic              out_load;
  logic [BYTE_W-1:0] tab_col;
  logic [COL_W-1:0]  w_col;
  logic [ROW_W:0]    w_row;
  logic [COL_W-1:0]  p_col;
  logic [ROW_W-1:0]  p_row;
  logic [COL_W-1:0]  p_wcol;
  logic [ROW_W-1:0]  p_wrow;
  logic [BYTE_W-1:0] p_char;
  logic              p_wr;
  logic              p_scroll;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign in_range  = (cmd.target_col < COL_W'(COLUMNS)) && (cmd.target_row < ROW_W'(ROWS));
  assign out_load  = (state == ST_DONE) && (!res.valid || res.ready);

  // put-character decode
  always_comb begin
    tab_col  = ({1'b0, col} + TAB_STEP) & TAB_MASK;
    w_col    = (col >= COL_W'(COLUMNS)) ? '0 : col;
    w_row    = (col >= COL_W'(COLUMNS)) ? {1'b0, row} + 1'b1 : {1'b0, row};
    p_col    = col;
    p_row    = row;
    p_wcol   = col;
    p_wrow   = row;
    p_char   = CH_SPACE;
    p_wr     = 1'b0;
    p_scroll = 1'b0;
    unique case (cmd.char_code)
      CH_NEWLINE: begin
        p_col = '0;
        if (row < ROW_W'(ROWS)) p_row = row + 1'b1;
      end
      CH_RETURN: begin
        p_col = '0;
      end
      CH_TAB: begin
        p_col = (tab_col > BYTE_W'(COLUMNS)) ? COL_W'(COLUMNS) : tab_col[COL_W-1:0];
      end
      CH_BACKSPACE: begin
        if (col != '0) begin
          p_col  = col - 1'b1;
          p_wcol = col - 1'b1;
          p_wr   = (row < ROW_W'(ROWS));
        end
      end
      default: begin
        p_scroll = (w_row >= (ROW_W+1)'(ROWS));
        p_wrow   = p_scroll ? ROW_W'(ROWS - 1) : w_row[ROW_W-1:0];
        p_wcol   = w_col;
        p_col    = w_col + 1'b1;
        p_row    = p_wrow;
        p_char   = cmd.char_code;
        p_wr     = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (idx == ADDR_W'(CELLS - 1)) begin
          if (pend_wr) state_next = ST_WRITE;
          else if (busy) state_next = ST_DONE;
          else state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd.func)
            FN_PUT: begin
              if (p_scroll) state_next = ST_SCROLL;
              else if (p_wr) state_next = ST_WRITE;
              else state_next = ST_DONE;
            end
            FN_SET:   state_next = ST_DONE;
            FN_CLEAR: state_next = ST_FILL;
            FN_READ:  state_next = in_range ? ST_READ : ST_DONE;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_SCROLL: if (idx == ADDR_W'(COPY_N - 1)) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_FILL;
      ST_WRITE:  state_next = ST_DONE;
      ST_READ:   state_next = ST_DONE;
      ST_DONE:   if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = ADDR_W'(cell_pos(cmd.target_row, cmd.target_col));
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = {attr, CH_SPACE};
    unique case (state)
      ST_IDLE: begin
        mem_re = accept && (cmd.func == FN_READ) && in_range;
      end
      ST_SCROLL: begin
        mem_re = 1'b1;
        mem_ra = idx + ADDR_W'(COLUMNS);
      end
      ST_FILL: begin
        mem_we = 1'b1;
        // the sweep after reset blanks with the reset attribute
        mem_wd = {(busy ? attr : ATTR_RESET), CH_SPACE};
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        mem_wa = waddr;
        mem_wd = {attr, pch};
      end
      default: begin
      end
    endcase
    // copy data lands in the cycle after its read
    if (cp_valid) begin
      mem_we = 1'b1;
      mem_wa = cp_addr;
      mem_wd = mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) screen[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= screen[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      attr      <= ATTR_RESET;
      col       <= '0;
      row       <= '0;
      idx       <= '0;
      cp_valid  <= 1'b0;
      pend_wr   <= 1'b0;
      busy      <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      state    <= state_next;
      cp_valid <= (state == ST_SCROLL);
      if (cfg_we) attr <= cfg_wdata;
      if (state == ST_SCROLL || state == ST_FILL) idx <= idx + 1'b1;
      if (state == ST_WRITE) pend_wr <= 1'b0;
      if (accept) begin
        busy <= 1'b1;
        unique case (cmd.func)
          FN_PUT: begin
            col     <= p_col;
            row     <= p_row;
            pend_wr <= p_wr;
            idx     <= '0;
          end
          FN_SET: begin
            if (in_range) begin
              col <= cmd.target_col;
              row <= cmd.target_row;
            end
          end
          FN_CLEAR: begin
            col     <= '0;
            row     <= '0;
            idx     <= '0;
            pend_wr <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (out_load) begin
        busy      <= 1'b0;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_addr <= idx;
    if (accept) begin
      waddr   <= ADDR_W'(cell_pos(p_wrow, p_wcol));
      pch     <= p_char;
      rd_char <= '0;
      rd_attr <= '0;
    end
    if (state == ST_READ) begin
      rd_char <= mem_q[BYTE_W-1:0];
      rd_attr <= mem_q[CELL_W-1:BYTE_W];
    end
    if (out_load) begin
      res.cursor_col      <= col;
      res.cursor_row      <= row;
      res.cursor_position <= cell_pos(row, col);
      res.read_char       <= rd_char;
      res.read_attr       <= rd_attr;
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("command taken but state stayed idle");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> mem_wa < ADDR_W'(CELLS))
    else $error("screen write beyond the store");

  a_cursor_bounded: assert property (@(posedge clk) disable iff (rst)
    col <= COL_W'(COLUMNS) && row <= ROW_W'(ROWS))
    else $error("cursor beyond saturation limits");

  a_copy_in_scroll: assert property (@(posedge clk) disable iff (rst)
    cp_valid |-> (state == ST_SCROLL || state == ST_DRAIN))
    else $error("copy write outside a scroll");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside completion");
`endif

endmodule

`default_nettype wire

[dv/tb_text_console_writer.sv]
`default_nettype none

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int WALK_BUDGET   = 100;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF      = 300;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] char_code;
    logic [COL_W-1:0]  target_col;
    logic [ROW_W-1:0]  target_row;
  } console_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_position;
    logic [BYTE_W-1:0] read_char;
    logic [BYTE_W-1:0] read_attr;
  } console_report_t;

  class console_tracker;
    logic [CELL_W-1:0] screen [CELLS];
    int                col;
    int                row;
    logic [BYTE_W-1:0] attr;
    console_report_t   due [$];
    int                failures;
    int                walks;

    function new();
      attr     = ATTR_RESET;
      col      = 0;
      row      = 0;
      failures = 0;
      walks    = 0;
      fill_blank();
    endfunction

    function void fill_blank();
      foreach (screen[i]) screen[i] = {attr, CH_SPACE};
    endfunction

    function void store(int c, int r, logic [BYTE_W-1:0] ch);
      if (c < COLUMNS && r < ROWS) screen[r * COLUMNS + c] = {attr, ch};
    endfunction

    function void scroll_up();
      for (int i = 0; i < COPY_N; i++) screen[i] = screen[i + COLUMNS];
      for (int i = COPY_N; i < CELLS; i++) screen[i] = {attr, CH_SPACE};
      walks++;
    endfunction

    function bit is_control(logic [BYTE_W-1:0] ch);
      return ch == CH_NEWLINE || ch == CH_RETURN || ch == CH_TAB || ch == CH_BACKSPACE;
    endfunction

    // true when putting ch at the current cursor would scroll the screen
    function bit put_walks(logic [BYTE_W-1:0] ch);
      if (is_control(ch)) return 1'b0;
      return row >= ROWS || (col >= COLUMNS && row + 1 >= ROWS);
    endfunction

    function void put_char(logic [BYTE_W-1:0] ch);
      case (ch)
        CH_NEWLINE: begin
          col = 0;
          if (row < ROWS) row++;
        end
        CH_RETURN: col = 0;
        CH_TAB: begin
          col = (col + int'(TAB_STEP)) & int'(TAB_MASK);
          if (col > COLUMNS) col = COLUMNS;
        end
        CH_BACKSPACE: begin
          if (col > 0) begin
            col--;
            store(col, row, CH_SPACE);
          end
        end
        default: begin
          if (col >= COLUMNS) begin
            col = 0;
            row++;
          end
          if (row >= ROWS) begin
            scroll_up();
            row = ROWS - 1;
          end
          store(col, row, ch);
          col++;
        end
      endcase
    endfunction

    function void take_command(console_cmd_t c);
      console_report_t r;
      bit              on_screen;
      r = '0;
      on_screen = c.target_col < COLUMNS && c.target_row < ROWS;
      case (c.func)
        FN_PUT: put_char(c.char_code);
        FN_SET: begin
          if (on_screen) begin
            col = c.target_col;
            row = c.target_row;
          end
        end
        FN_CLEAR: begin
          fill_blank();
          walks++;
          col = 0;
          row = 0;
        end
        default: begin
          if (on_screen)
            {r.read_attr, r.read_char} = screen[c.target_row * COLUMNS + c.target_col];
        end
      endcase
      r.cursor_col      = COL_W'(col);
      r.cursor_row      = ROW_W'(row);
      r.cursor_position = POS_W'(row * COLUMNS + col);
      due.push_back(r);
    endfunction

    function void check_result(console_report_t got);
      console_report_t want;
      if (due.size() == 0) begin
        $error("result with nothing due: col %0d row %0d", got.cursor_col, got.cursor_row);
        failures++;
        return;
      end
      want = due.pop_front();
      if (got.cursor_col !== want.cursor_col) begin
        $error("cursor_col expected %0d got %0d", want.cursor_col, got.cursor_col);
        failures++;
      end
      if (got.cursor_row !== want.cursor_row) begin
        $error("cursor_row expected %0d got %0d", want.cursor_row, got.cursor_row);
        failures++;
      end
      if (got.cursor_position !== want.cursor_position) begin
        $error("cursor_position expected %0d got %0d", want.cursor_position,
               got.cursor_position);
        failures++;
      end
      if (got.read_char !== want.read_char) begin
        $error("read_char expected %0h got %0h", want.read_char, got.read_char);
        failures++;
      end
      if (got.read_attr !== want.read_attr) begin
        $error("read_attr expected %0h got %0h", want.read_attr, got.read_attr);
        failures++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;
  int                tx_idle_pct;
  int                rx_stall_pct;
  int                hold_off_len;
  int                cycle_count;
  console_tracker    tracker = new();

  tcw_cmd_if cmd_bus ();
  tcw_res_if res_bus ();

  text_console_writer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_bus),
    .res       (res_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit roll(int pct);
    return pct != 0 && $urandom_range(0, 99) < pct;
  endfunction

  function automatic console_cmd_t cmd_of(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] ch,
                                          int tcol, int trow);
    console_cmd_t c;
    c.func       = func;
    c.char_code  = ch;
    c.target_col = COL_W'(tcol);
    c.target_row = ROW_W'(trow);
    return c;
  endfunction

  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int           pick;
    bit           capped;
    pick         = $urandom_range(0, 99);
    capped       = tracker.walks >= WALK_BUDGET;
    c.char_code  = BYTE_W'($urandom);
    c.target_col = COL_W'($urandom);
    c.target_row = ROW_W'($urandom);
    if (pick < 55) begin
      c.func = FN_PUT;
      case ($urandom_range(0, 9))
        0: c.char_code = CH_NEWLINE;
        1: c.char_code = CH_RETURN;
        2: c.char_code = CH_TAB;
        3, 4: c.char_code = CH_BACKSPACE;
        default: ;
      endcase
    end else if (pick < 75) begin
      c.func = FN_SET;
      if ($urandom_range(0, 4) != 0) begin
        c.target_col = COL_W'($urandom_range(0, COLUMNS - 1));
        if ($urandom_range(0, 1))
          c.target_row = ROW_W'(ROWS - 1 - $urandom_range(0, 4));
        else
          c.target_row = ROW_W'($urandom_range(0, ROWS - 1));
      end
    end else if (pick < 98 || capped) begin
      c.func = FN_READ;
      if ($urandom_range(0, 4) != 0) begin
        c.target_col = COL_W'($urandom_range(0, COLUMNS - 1));
        c.target_row = ROW_W'($urandom_range(0, ROWS - 1));
      end
    end else begin
      c.func = FN_CLEAR;
    end
    // keep the number of screen walks bounded
    if (capped && c.func == FN_PUT && tracker.put_walks(c.char_code)) begin
      c.func       = FN_SET;
      c.target_col = COL_W'($urandom_range(0, COLUMNS - 1));
      c.target_row = ROW_W'($urandom_range(0, ROWS - 2));
    end
    return c;
  endfunction

  task automatic offer(input console_cmd_t c);
    if (roll(tx_idle_pct)) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
      while (roll(tx_idle_pct)) @(posedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.func       <= c.func;
    cmd_bus.char_code  <= c.char_code;
    cmd_bus.target_col <= c.target_col;
    cmd_bus.target_row <= c.target_row;
    do @(posedge clk); while (!cmd_bus.ready);
    tracker.take_command(c);
  endtask

  task automatic drive_random(input int count);
    for (int i = 0; i < count; i++) offer(random_command());
  endtask

  task automatic drain();
    cmd_bus.valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [BYTE_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we      <= 1'b0;
    tracker.attr = value;
  endtask

  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_bus.valid && res_bus.ready)
        tracker.check_result({res_bus.cursor_col, res_bus.cursor_row, res_bus.cursor_position,
                              res_bus.read_char, res_bus.read_attr});
      if (hold_off_len > 0) begin
        res_bus.ready <= 1'b0;
        hold_off_len--;
      end else begin
        res_bus.ready <= !roll(rx_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_text_console_writer NOT OK");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.func       = FN_PUT;
    cmd_bus.char_code  = '0;
    cmd_bus.target_col = '0;
    cmd_bus.target_row = '0;
    tx_idle_pct        = 0;
    rx_stall_pct       = 0;
    hold_off_len       = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    offer(cmd_of(FN_READ, 8'h00, 0, 0));
    offer(cmd_of(FN_READ, 8'h00, COLUMNS - 1, ROWS - 1));
    offer(cmd_of(FN_READ, 8'h00, COLUMNS, 0));
    offer(cmd_of(FN_READ, 8'hFF, 127, 31));
    offer(cmd_of(FN_PUT, 8'h41, 0, 0));
    offer(cmd_of(FN_PUT, 8'hFF, 0, 0));
    offer(cmd_of(FN_PUT, CH_BACKSPACE, 0, 0));
    offer(cmd_of(FN_PUT, CH_TAB, 0, 0));
    offer(cmd_of(FN_SET, 8'h00, COLUMNS - 3, 0));
    offer(cmd_of(FN_PUT, CH_TAB, 0, 0));
    offer(cmd_of(FN_PUT, 8'h78, 0, 0));
    offer(cmd_of(FN_PUT, CH_RETURN, 0, 0));
    offer(cmd_of(FN_PUT, CH_BACKSPACE, 0, 0));
    offer(cmd_of(FN_SET, 8'h00, COLUMNS - 1, ROWS - 1));
    offer(cmd_of(FN_PUT, 8'h7A, 0, 0));
    offer(cmd_of(FN_PUT, 8'h71, 0, 0));
    offer(cmd_of(FN_PUT, CH_NEWLINE, 0, 0));
    offer(cmd_of(FN_PUT, CH_NEWLINE, 0, 0));
    offer(cmd_of(FN_PUT, CH_TAB, 0, 0));
    offer(cmd_of(FN_PUT, CH_BACKSPACE, 0, 0));
    offer(cmd_of(FN_PUT, 8'h77, 0, 0));
    offer(cmd_of(FN_SET, 8'h00, 127, 31));
    offer(cmd_of(FN_READ, 8'h00, COLUMNS - 1, ROWS - 2));
    offer(cmd_of(FN_CLEAR, 8'h00, 0, 0));
    offer(cmd_of(FN_READ, 8'h00, 0, 0));

    set_attribute(8'hFF);
    drive_random(300);

    set_attribute(8'h00);
    tx_idle_pct = 85;
    drive_random(150);
    drain();
    drive_random(150);

    set_attribute(BYTE_W'($urandom_range(0, 255)));
    tx_idle_pct  = 0;
    rx_stall_pct = 85;
    drive_random(300);

    set_attribute(BYTE_W'($urandom_range(0, 255)));
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    hold_off_len = HOLD_OFF;
    drive_random(300);

    drain();
    repeat (20) @(posedge clk);
    if (tracker.failures == 0)
      $display("tb_text_console_writer OK");
    else
      $display("tb_text_console_writer NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
src/tcw_pkg.sv
src/tcw_if.sv
src/text_console_writer.sv
dv/tb_text_console_writer.sv
